// ===== rtl/core/tsds_pkg.sv =====
// ----------------------------------------------------------------------------
// tsds_pkg
// shared types, constants and stencil coefficients for the time second
// derivative stencil
// ----------------------------------------------------------------------------
package tsds_pkg;

  localparam int unsigned DefMaxSlice = 4096;
  localparam int unsigned DefMaxTime  = 4096;
  localparam int unsigned WinRows     = 11;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CoefW       = 34;
  localparam int unsigned DataW       = 32;

  localparam logic [1:0] CFG_SLICE_LEN = 2'd0;
  localparam logic [1:0] CFG_TIME_LEN  = 2'd1;
  localparam logic [1:0] CFG_INV_DT_SQ = 2'd2;

  typedef enum logic [1:0] {
    SEL_DERIV,
    SEL_IC_DIFF,
    SEL_IC_ROW1
  } sel_e;

  typedef struct packed {
    logic             wr_en;
    logic [SlotW-1:0] slot;
    logic             first_en;
    logic             first_row;
  } wr_ctl_t;

  typedef struct packed {
    sel_e                    sel;
    logic                    last;
    logic signed [DataW-1:0] ic;
  } meta_t;

  // base constant in signed q3.30, nearest integer of a * 2^30 / 10^11
  function automatic longint q30(longint a);
    return ((a <<< 19) + 64'sd24414062) / 64'sd48828125;
  endfunction

  localparam logic signed [CoefW-1:0] COEF [0:5][0:5] = '{
    '{34'sd0, 34'sd0, 34'sd0, 34'sd0, 34'sd0, 34'sd0},
    '{CoefW'(-q30(64'sd200000000000)), CoefW'(q30(64'sd100000000000)),
      34'sd0, 34'sd0, 34'sd0, 34'sd0},
    '{CoefW'(-q30(64'sd250000000000)), CoefW'(q30(64'sd133333333333)),
      CoefW'(-q30(64'sd8333333333)), 34'sd0, 34'sd0, 34'sd0},
    '{CoefW'(-q30(64'sd272222222222)), CoefW'(q30(64'sd150000000000)),
      CoefW'(-q30(64'sd15000000000)), CoefW'(q30(64'sd1111111111)),
      34'sd0, 34'sd0},
    '{CoefW'(-q30(64'sd284722222222)), CoefW'(q30(64'sd160000000000)),
      CoefW'(-q30(64'sd20000000000)), CoefW'(q30(64'sd2539682539)),
      CoefW'(-q30(64'sd178571428)), 34'sd0},
    '{CoefW'(-q30(64'sd292722222200)), CoefW'(q30(64'sd166666666700)),
      CoefW'(-q30(64'sd23809524000)), CoefW'(q30(64'sd3968254000)),
      CoefW'(-q30(64'sd496032000)), CoefW'(q30(64'sd31746000))}
  };

endpackage

// ===== rtl/core/tsds_mem.sv =====
// ----------------------------------------------------------------------------
// tsds_mem
// eleven-slice window banks plus the two first-slice banks, one write and
// one registered read of every bank per cycle
// ----------------------------------------------------------------------------
module tsds_mem #(
  parameter int unsigned MAX_SLICE = tsds_pkg::DefMaxSlice,
  parameter int unsigned AW        = (MAX_SLICE > 1) ? $clog2(MAX_SLICE) : 1
) (
  input  logic                     clk_i,
  input  tsds_pkg::wr_ctl_t        wr_ctl_i,
  input  logic [AW-1:0]            wr_addr_i,
  input  logic [31:0]              wr_data_i,
  input  logic                     rd_en_i,
  input  logic [AW-1:0]            rd_addr_i,
  output logic [31:0]              rd_win_o [tsds_pkg::WinRows],
  output logic [31:0]              rd_f0_o,
  output logic [31:0]              rd_f1_o
);

  for (genvar b = 0; b < tsds_pkg::WinRows; b++) begin : g_bank
    logic [31:0] mem [MAX_SLICE];
    always_ff @(posedge clk_i) begin
      if (wr_ctl_i.wr_en && (wr_ctl_i.slot == tsds_pkg::SlotW'(b))) begin
        mem[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_win_o[b] <= mem[rd_addr_i];
      end
    end
  end

  logic [31:0] first0 [MAX_SLICE];
  logic [31:0] first1 [MAX_SLICE];

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.first_en && !wr_ctl_i.first_row) begin
      first0[wr_addr_i] <= wr_data_i;
    end
    if (wr_ctl_i.first_en && wr_ctl_i.first_row) begin
      first1[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_f0_o <= first0[rd_addr_i];
      rd_f1_o <= first1[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/time_second_derivative_stencil_top.sv =====
// ----------------------------------------------------------------------------
// time_second_derivative_stencil_top
// second time derivative of a time-major wavefield volume, 10th order inside
// falling to 2nd order at the ends, initial-condition rows at the end
//
//  channel  | direction | signals                     | request
//  s_axis   | in        | tvalid tready tdata tuser   | sample or drain tick
//  m_axis   | out       | tvalid tready tdata tlast   | output sample
//  cfg      | in        | valid ready index data      | register write
//
// one request per cycle unless the output is stalled; a result is offered from the stage 9 output register
// the whole pipeline advances together, frozen while the output is stalled
// reset clears counters, valid bits and configuration registers only; stores need no clearing pass
// eleven window banks read in parallel at one address supply every tap
// ----------------------------------------------------------------------------
module time_second_derivative_stencil_top #(
  parameter int unsigned MAX_SLICE = tsds_pkg::DefMaxSlice,
  parameter int unsigned MAX_TIME  = tsds_pkg::DefMaxTime
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // sample
  input  logic [0:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW  = (MAX_SLICE > 1) ? $clog2(MAX_SLICE) : 1;
  localparam int unsigned PW  = $clog2(MAX_SLICE + 1);
  localparam int unsigned RW  = $clog2(MAX_TIME + 1);
  localparam int unsigned NL  = tsds_pkg::WinRows;
  localparam int unsigned CW  = tsds_pkg::CoefW;
  localparam int unsigned SW  = 68;
  localparam int unsigned TW  = 104;
  localparam int unsigned SLW = tsds_pkg::SlotW;
  localparam int unsigned SliceRst = (MAX_SLICE < 4096) ? MAX_SLICE : 4096;

  // configuration
  logic [PW-1:0] slice_q;
  logic [RW-1:0] time_q;
  logic [31:0]   inv_q;
  logic          cfg_fire;
  logic [PW-1:0] slice_eff;
  logic [RW-1:0] time_eff;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;

  always_comb begin
    if (cfg_data_i[12:0] == 13'd0) begin
      slice_eff = PW'(1);
    end else if (32'(cfg_data_i[12:0]) > MAX_SLICE) begin
      slice_eff = PW'(MAX_SLICE);
    end else begin
      slice_eff = PW'(cfg_data_i[12:0]);
    end
    if (cfg_data_i[12:0] < 13'd12) begin
      time_eff = RW'(12);
    end else if (32'(cfg_data_i[12:0]) > MAX_TIME) begin
      time_eff = RW'(MAX_TIME);
    end else begin
      time_eff = RW'(cfg_data_i[12:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= PW'(SliceRst);
      time_q  <= RW'(12);
      inv_q   <= 32'd65536;
    end else if (cfg_fire) begin
      if (cfg_index_i == tsds_pkg::CFG_SLICE_LEN) slice_q <= slice_eff;
      if (cfg_index_i == tsds_pkg::CFG_TIME_LEN)  time_q  <= time_eff;
      if (cfg_index_i == tsds_pkg::CFG_INV_DT_SQ) inv_q   <= cfg_data_i;
    end
  end

  // pipeline enable
  logic en, s_fire;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // stage 0: counters and issue
  logic [RW-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
  logic [PW-1:0]  in_pos_q, in_pos_d, out_pos_q, out_pos_d;
  logic [SLW-1:0] in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic           do_wr, emit, last0, deriv_row;
  logic [RW:0]    c_w, tail_w, h_w, need_w;
  logic [2:0]     h0;
  logic [SLW:0]   base_w;
  tsds_pkg::sel_e sel0;
  tsds_pkg::wr_ctl_t wr_ctl;

  always_comb begin
    in_row_d   = in_row_q;
    in_pos_d   = in_pos_q;
    in_slot_d  = in_slot_q;
    out_row_d  = out_row_q;
    out_pos_d  = out_pos_q;
    out_slot_d = out_slot_q;
    do_wr = s_fire && !s_axis_tuser[0] && (in_row_q < time_q);
    if (do_wr) begin
      if ((PW+1)'(in_pos_q) + 1'b1 >= (PW+1)'(slice_q)) begin
        in_pos_d  = '0;
        in_row_d  = in_row_q + 1'b1;
        in_slot_d = (in_slot_q == SLW'(NL - 1)) ? '0 : in_slot_q + 1'b1;
      end else begin
        in_pos_d = in_pos_q + 1'b1;
      end
    end
    deriv_row = ((RW+1)'(out_row_q) + 2'd2) < (RW+1)'(time_q);
    c_w    = (RW+1)'(out_row_q) + 1'b1;
    tail_w = (RW+1)'(time_q) - (RW+1)'(out_row_q) - 2'd2;
    h_w    = c_w;
    if (tail_w < h_w) h_w = tail_w;
    if (h_w > (RW+1)'(5)) h_w = (RW+1)'(5);
    h0     = h_w[2:0];
    need_w = c_w + h_w;
    if (out_row_q >= time_q) begin
      emit = 1'b0;
    end else if (deriv_row) begin
      emit = s_fire && (((RW+1)'(in_row_d) > need_w) ||
             (((RW+1)'(in_row_d) == need_w) && (in_pos_d > out_pos_q)));
    end else begin
      emit = s_fire && (in_row_d >= time_q);
    end
    if (deriv_row) begin
      sel0 = tsds_pkg::SEL_DERIV;
    end else if ((RW+1)'(out_row_q) + 2'd2 == (RW+1)'(time_q)) begin
      sel0 = tsds_pkg::SEL_IC_DIFF;
    end else begin
      sel0 = tsds_pkg::SEL_IC_ROW1;
    end
    last0 = ((RW+1)'(out_row_q) + 1'b1 == (RW+1)'(time_q)) &&
            ((PW+1)'(out_pos_q) + 1'b1 >= (PW+1)'(slice_q));
    base_w = (SLW+1)'(out_slot_q) + (SLW+1)'(7);
    if (base_w >= (SLW+1)'(NL)) base_w = base_w - (SLW+1)'(NL);
    if (emit) begin
      if ((PW+1)'(out_pos_q) + 1'b1 >= (PW+1)'(slice_q)) begin
        out_pos_d  = '0;
        out_row_d  = out_row_q + 1'b1;
        out_slot_d = (out_slot_q == SLW'(NL - 1)) ? '0 : out_slot_q + 1'b1;
      end else begin
        out_pos_d = out_pos_q + 1'b1;
      end
    end
    if ((emit && last0) || (cfg_fire && ((cfg_index_i == tsds_pkg::CFG_SLICE_LEN) ||
        (cfg_index_i == tsds_pkg::CFG_TIME_LEN)))) begin
      in_row_d = '0; in_pos_d = '0; in_slot_d = '0;
      out_row_d = '0; out_pos_d = '0; out_slot_d = '0;
    end
    wr_ctl.wr_en     = do_wr;
    wr_ctl.slot      = in_slot_q;
    wr_ctl.first_en  = do_wr && (in_row_q < RW'(2));
    wr_ctl.first_row = in_row_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0; in_pos_q <= '0; in_slot_q <= '0;
      out_row_q <= '0; out_pos_q <= '0; out_slot_q <= '0;
    end else begin
      in_row_q <= in_row_d; in_pos_q <= in_pos_d; in_slot_q <= in_slot_d;
      out_row_q <= out_row_d; out_pos_q <= out_pos_d; out_slot_q <= out_slot_d;
    end
  end

  // valid bits
  logic [9:1] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[8:1], emit};
    end
  end
  assign m_axis_tvalid = v_q[9];

  // stage 1: read request
  logic [AW-1:0]  pos1_q;
  logic [2:0]     h1_q, h2_q;
  logic [SLW-1:0] base1_q, base2_q;
  tsds_pkg::sel_e sel1_q, sel2_q;
  logic           last1_q, last2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos1_q <= out_pos_q[AW-1:0];
      h1_q <= h0; base1_q <= base_w[SLW-1:0]; sel1_q <= sel0; last1_q <= last0;
      h2_q <= h1_q; base2_q <= base1_q; sel2_q <= sel1_q; last2_q <= last1_q;
    end
  end

  // stage 2: memory data
  logic [31:0] win2 [NL];
  logic [31:0] f0_2, f1_2;

  tsds_mem #(.MAX_SLICE(MAX_SLICE), .AW(AW)) u_mem (
    .clk_i     (clk_i),
    .wr_ctl_i  (wr_ctl),
    .wr_addr_i (in_pos_q[AW-1:0]),
    .wr_data_i (s_axis_tdata),
    .rd_en_i   (en),
    .rd_addr_i (pos1_q),
    .rd_win_o  (win2),
    .rd_f0_o   (f0_2),
    .rd_f1_o   (f1_2)
  );

  // stage 3: tap rotation, coefficient select, initial-condition value
  logic signed [31:0]   tap3_d [NL];
  logic signed [CW-1:0] coef3_d [NL];
  logic signed [31:0]   tap3_q [NL];
  logic signed [CW-1:0] coef3_q [NL];
  logic signed [32:0]   icd;
  tsds_pkg::meta_t      meta3_d;

  always_comb begin
    for (int j = 0; j < NL; j++) begin
      logic [SLW:0] idx;
      logic [2:0]   d;
      idx = (SLW+1)'(base2_q) + (SLW+1)'(j);
      if (idx >= (SLW+1)'(NL)) idx = idx - (SLW+1)'(NL);
      d = (j >= 5) ? 3'(j - 5) : 3'(5 - j);
      if (d <= h2_q) begin
        tap3_d[j]  = $signed(win2[idx[SLW-1:0]]);
        coef3_d[j] = tsds_pkg::COEF[h2_q][d];
      end else begin
        tap3_d[j]  = '0;
        coef3_d[j] = '0;
      end
    end
    icd = $signed({f0_2[31], f0_2}) - $signed({f1_2[31], f1_2});
    meta3_d.sel  = sel2_q;
    meta3_d.last = last2_q;
    if (sel2_q == tsds_pkg::SEL_IC_DIFF) begin
      if (icd > 33'sh0_7FFF_FFFF) begin
        meta3_d.ic = 32'sh7FFF_FFFF;
      end else if (icd < -33'sh0_8000_0000) begin
        meta3_d.ic = 32'sh8000_0000;
      end else begin
        meta3_d.ic = icd[31:0];
      end
    end else begin
      meta3_d.ic = $signed(f1_2);
    end
  end

  // stages 4 to 8: products, adder tree, scaling by inv_dt_sq
  logic signed [CW+31:0] prod4_q [NL];
  logic signed [SW-1:0]  pair5_q [6];
  logic signed [SW-1:0]  grp6_q [2];
  logic signed [SW-1:0]  sum7_q;
  logic signed [SW-1:0]  ph8_q;
  logic [64:0]           pl8_q;
  tsds_pkg::meta_t       meta_q [3:8];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tap3_q  <= tap3_d;
      coef3_q <= coef3_d;
      for (int j = 0; j < NL; j++) begin
        prod4_q[j] <= coef3_q[j] * tap3_q[j];
      end
      for (int i = 0; i < 5; i++) begin
        pair5_q[i] <= SW'(prod4_q[2*i]) + SW'(prod4_q[2*i+1]);
      end
      pair5_q[5] <= SW'(prod4_q[10]);
      grp6_q[0]  <= pair5_q[0] + pair5_q[1] + pair5_q[2];
      grp6_q[1]  <= pair5_q[3] + pair5_q[4] + pair5_q[5];
      sum7_q     <= grp6_q[0] + grp6_q[1];
      ph8_q      <= $signed(sum7_q[SW-1:33]) * $signed({1'b0, inv_q});
      pl8_q      <= sum7_q[32:0] * inv_q;
      meta_q[3]  <= meta3_d;
      for (int s = 4; s <= 8; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  // stage 9: round, saturate, output register
  logic signed [TW-1:0] tot;
  logic signed [TW-47:0] rnd;
  logic signed [31:0]   val9;

  always_comb begin
    tot = (TW'(ph8_q) <<< 33) + $signed(TW'(pl8_q)) + (TW'(1) <<< 45);
    rnd = tot[TW-1:46];
    if (rnd > (TW-46)'(32'sh7FFF_FFFF)) begin
      val9 = 32'sh7FFF_FFFF;
    end else if (rnd < -(TW-46)'(64'sh8000_0000)) begin
      val9 = 32'sh8000_0000;
    end else begin
      val9 = rnd[31:0];
    end
    if (meta_q[8].sel != tsds_pkg::SEL_DERIV) val9 = meta_q[8].ic;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= val9;
      m_axis_tlast <= meta_q[8].last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_row_q < time_q)
    else $error("output row past the volume");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_row_q <= time_q)
    else $error("input row past the volume");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (in_pos_q < slice_q) && (out_pos_q < slice_q))
    else $error("position counter past the slice");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (emit && last0) |=> (out_row_q == '0))
    else $error("volume did not restart after last output");

endmodule
